[design/sce_pkg.sv]
`timescale 1ns / 1ps

package sce_pkg;

    typedef enum logic [2:0] {
        MODE_ENV_WRITE  = 3'd0,
        MODE_LEN_WRITE  = 3'd1,
        MODE_LEN_ENABLE = 3'd2,
        MODE_TRIGGER    = 3'd3,
        MODE_LEN_TICK   = 3'd4,
        MODE_ENV_TICK   = 3'd5,
        MODE_RESET      = 3'd6
    } mode_t;

    localparam logic [8:0] LENGTH_MAX_RESET = 9'd64;
    localparam logic [8:0] LENGTH_MAX_LIMIT = 9'd256;
    localparam logic [7:0] DAC_MASK         = 8'hF8;
    localparam logic [3:0] VOL_MAX          = 4'hF;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic       channel_on;
        logic [3:0] volume_level;
        logic [7:0] envelope_readback;
        logic       dac_enabled;
        logic       length_on;
        logic [8:0] length_left;
    } out_item_t;

endpackage

[design/sound_channel_envelope_length_unit.sv]
`timescale 1ns / 1ps
// An accepted item goes through the input register, then the result register, to result valid.
// Throughput: one item per cycle while out_stall is low; the whole state update is one pass
// of logic between the input register and the result register.
// Stall from the output side backs up into in_stall only when both registers hold items.
// Reset (rst_n low, asynchronous): channel state cleared, length_max back to 64,
// no items held.
module sound_channel_envelope_length_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sce_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output sce_pkg::out_item_t  out_item,
    input  logic                cfg_wr_en,
    input  logic [8:0]          cfg_wr_data
);
    import sce_pkg::*;

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    logic [8:0] length_max_reg;

    logic [7:0] env_reg,    env_next;
    logic [2:0] env_count_reg,  env_count_next;
    logic [2:0] env_period_reg, env_period_next;
    logic       env_up_reg,     env_up_next;
    logic [3:0] vol_reg,        vol_next;
    logic [8:0] len_count_reg,  len_count_next;
    logic       len_enable_reg, len_enable_next;
    logic       dac_flag_reg,   dac_flag_next;
    logic       active_reg,     active_next;

    logic       advance;
    logic       step;
    logic [2:0] env_count_inc;
    logic [8:0] len_count_dec;
    out_item_t  result;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign env_count_inc = env_count_reg + 3'd1;
    assign len_count_dec = len_count_reg - 9'd1;

    always_comb
    begin
        env_next        = env_reg;
        env_count_next  = env_count_reg;
        env_period_next = env_period_reg;
        env_up_next     = env_up_reg;
        vol_next        = vol_reg;
        len_count_next  = len_count_reg;
        len_enable_next = len_enable_reg;
        dac_flag_next   = dac_flag_reg;
        active_next     = active_reg;
        case (in_item_reg.mode)
            MODE_ENV_WRITE:
            begin
                dac_flag_next = |(in_item_reg.data & DAC_MASK);
                if (!dac_flag_next)
                begin
                    active_next = 1'b0;
                end
                env_next = in_item_reg.data;
            end
            MODE_LEN_WRITE:
            begin
                len_count_next = {1'b0, in_item_reg.data};
            end
            MODE_LEN_ENABLE:
            begin
                len_enable_next = in_item_reg.data[0];
            end
            MODE_TRIGGER:
            begin
                env_count_next  = 3'd0;
                env_period_next = env_reg[2:0];
                env_up_next     = env_reg[3];
                vol_next        = env_reg[7:4];
                if (len_count_reg == 9'd0)
                begin
                    len_count_next = length_max_reg;
                end
                active_next = dac_flag_reg;
            end
            MODE_LEN_TICK:
            begin
                if (len_enable_reg && len_count_reg != 9'd0)
                begin
                    len_count_next = len_count_dec;
                    if (len_count_dec == 9'd0)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            MODE_ENV_TICK:
            begin
                if (env_period_reg != 3'd0)
                begin
                    env_count_next = env_count_inc;
                    if (env_count_inc == env_period_reg)
                    begin
                        env_count_next = 3'd0;
                        // saturate at either end
                        if (env_up_reg)
                        begin
                            if (vol_reg != VOL_MAX)
                            begin
                                vol_next = vol_reg + 4'd1;
                            end
                        end
                        else if (vol_reg != 4'd0)
                        begin
                            vol_next = vol_reg - 4'd1;
                        end
                    end
                end
            end
            MODE_RESET:
            begin
                env_next        = 8'd0;
                env_count_next  = 3'd0;
                env_period_next = 3'd0;
                env_up_next     = 1'b0;
                vol_next        = 4'd0;
                len_count_next  = 9'd0;
                len_enable_next = 1'b0;
                dac_flag_next   = 1'b0;
                active_next     = 1'b0;
            end
            default:
            begin
            end
        endcase

        result.channel_on        = active_next;
        result.volume_level      = vol_next;
        result.envelope_readback = env_next;
        result.dac_enabled       = dac_flag_next;
        result.length_on         = len_enable_next;
        result.length_left       = len_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_max_reg <= LENGTH_MAX_RESET;
        end
        else if (cfg_wr_en)
        begin
            // clamp anything above 256
            length_max_reg <= (cfg_wr_data > LENGTH_MAX_LIMIT) ? LENGTH_MAX_LIMIT : cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
        if (step)
        begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg        <= 8'd0;
            env_count_reg  <= 3'd0;
            env_period_reg <= 3'd0;
            env_up_reg     <= 1'b0;
            vol_reg        <= 4'd0;
            len_count_reg  <= 9'd0;
            len_enable_reg <= 1'b0;
            dac_flag_reg   <= 1'b0;
            active_reg     <= 1'b0;
        end
        else if (step)
        begin
            env_reg        <= env_next;
            env_count_reg  <= env_count_next;
            env_period_reg <= env_period_next;
            env_up_reg     <= env_up_next;
            vol_reg        <= vol_next;
            len_count_reg  <= len_count_next;
            len_enable_reg <= len_enable_next;
            dac_flag_reg   <= dac_flag_next;
            active_reg     <= active_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_active_needs_dac: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> dac_flag_reg)
        else $error("channel active without DAC power");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while result register can drain");

    a_length_max_range: assert property (@(posedge clk) disable iff (!rst_n)
        length_max_reg <= LENGTH_MAX_LIMIT)
        else $error("length_max above limit");

    a_reset_item_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_item_reg.mode == MODE_RESET) |=> (!active_reg && len_count_reg == 9'd0))
        else $error("channel reset item left state behind");
`endif

endmodule
